>>> design/tcls_pkg.sv
// Shared codes and types for the three-class lane credit scheduler.
`default_nettype none
package tcls_pkg;

   // Operation codes carried on the request side
   localparam logic [1:0] OP_SUBMIT      = 2'd0;
   localparam logic [1:0] OP_COMPLETE    = 2'd1;
   localparam logic [1:0] OP_CANCEL_RECV = 2'd2;
   localparam logic [1:0] OP_CANCEL_ALL  = 2'd3;

   // Class and lane codes
   localparam logic [1:0] CLS_HIGH = 2'd0;
   localparam logic [1:0] CLS_STD  = 2'd1;
   localparam logic [1:0] CLS_LOW  = 2'd2;
   localparam int         NUM_CLS  = 3;

   // Result status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_IDLE_LANE = 2'd2;

   // Register indexes
   localparam logic [2:0] REG_HIGH_LIMIT = 3'd0;
   localparam logic [2:0] REG_STD_LIMIT  = 3'd1;
   localparam logic [2:0] REG_LOW_LIMIT  = 3'd2;
   localparam logic [2:0] REG_HIGH_TH    = 3'd3;
   localparam logic [2:0] REG_LOW_TH     = 3'd4;

   localparam int PRIO_BITS = 16;

   typedef enum logic [2:0] {
      S_IDLE, S_OP, S_SWEEP, S_PICK, S_SCAN, S_TAKE, S_DONE
   } state_type;

   // Commands from the sequencer to one class store
   typedef struct packed {
      logic append;
      logic remove;
      logic clear;
   } store_cmd_type;

endpackage
`default_nettype wire

>>> design/three_class_lane_credit_scheduler_top.sv
// Top level of the three-class lane credit scheduler: sequencer, lane credits and counters.
// Each request beat (submit, completion, cancel-by-receiver, cancel-all) yields exactly one
// response beat carrying the issued command, if any, a status and two running totals. The
// block works on one beat at a time: a submit, completion or cancel-all runs OP, PICK,
// SCAN (a minimum-priority scan over the entries of the issuing class), TAKE and DONE, or
// OP, PICK and DONE when nothing is issued; a cancel-by-receiver first sweeps every entry
// of each store in turn. The three class stores are rows of CLASS_DEPTH cells kept in
// arrival order; a removal shifts every later cell one place toward the head. A new
// request beat is taken while the previous response waits in the output register.
`default_nettype none
module three_class_lane_credit_scheduler_top #(
   parameter int CLASS_DEPTH   = 16,
   parameter int TAG_BITS      = 16,
   parameter int RECEIVER_BITS = 8
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   // opcode
   input  wire logic [1:0]          req_tuser,
   // request_priority, receiver_id, command_tag, completed_lane, zero fill
   input  wire logic [((tcls_pkg::PRIO_BITS+RECEIVER_BITS+TAG_BITS+2+7)/8)*8-1:0] req_tdata,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   // issue_valid, issue_tag, issue_receiver, issue_lane, status,
   // scheduled_count, processed_count, zero fill
   output logic [((1+TAG_BITS+RECEIVER_BITS+2+2+32+32+7)/8)*8-1:0] rsp_tdata,
   input  wire logic                csr_wen,
   input  wire logic [2:0]          csr_addr,
   input  wire logic [15:0]         csr_wdata
);
   import tcls_pkg::*;

   localparam int RB       = RECEIVER_BITS;
   localparam int TB       = TAG_BITS;
   localparam int EW       = PRIO_BITS + RB + TB;
   localparam int IW       = $clog2(CLASS_DEPTH);
   localparam int CW       = $clog2(CLASS_DEPTH + 1);
   localparam int RSP_BITS = 1 + TB + RB + 2 + 2 + 32 + 32;
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8;

   // Configuration registers
   logic [7:0]  lim_ff [NUM_CLS];
   logic signed [15:0] high_th_ff;
   logic [14:0] low_th_ff;

   // Latched request
   logic [1:0]                 op_ff;
   logic signed [PRIO_BITS-1:0] prio_ff;
   logic [RB-1:0]              recv_ff;
   logic [TB-1:0]              tag_ff;
   logic [1:0]                 lane_ff;

   // Sequencer state
   state_type   state_ff, state_in;
   logic [1:0]  sel_cls_ff;
   logic [1:0]  iss_lane_ff;
   logic [CW-1:0] idx_ff;
   logic signed [PRIO_BITS-1:0] best_prio_ff;
   logic [IW-1:0] best_idx_ff;
   logic [TB-1:0] best_tag_ff;
   logic [RB-1:0] best_recv_ff;
   logic [7:0]  active_ff [NUM_CLS];
   logic [31:0] sched_ff, proc_ff;
   logic        iss_valid_ff;
   logic [1:0]  status_ff;
   logic        rsp_valid_ff;
   logic [RSP_W-1:0] rsp_data_ff;

   // Store interface
   store_cmd_type cmd   [NUM_CLS];
   logic [EW-1:0] rd_e  [NUM_CLS];
   logic [CW-1:0] cnt   [NUM_CLS];
   logic [IW-1:0] pos;
   logic [EW-1:0] new_entry;

   logic          req_fire, push_ok;
   logic [1:0]    sub_cls;
   logic          sub_full;
   logic [EW-1:0] sel_e;
   logic signed [PRIO_BITS-1:0] sel_prio;
   logic [RB-1:0] sel_recv;
   logic [TB-1:0] sel_tag;
   logic          scan_end, sweep_hit;
   logic          free0, free1, free2, pick_go;
   logic [1:0]    pick_cls, pick_lane;

   for (genvar c = 0; c < NUM_CLS; c++) begin : g_store
      tcls_store #(
         .DEPTH(CLASS_DEPTH), .ENTRY_BITS(EW), .IDX_BITS(IW), .CNT_BITS(CW)
      ) u_store (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd[c]),
         .pos       (pos),
         .new_entry (new_entry),
         .rd_idx    (idx_ff[IW-1:0]),
         .rd_entry  (rd_e[c]),
         .count     (cnt[c])
      );
   end

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign push_ok    = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Classify a submit against the thresholds, high test first
   always_comb begin
      if (prio_ff <= high_th_ff) begin
         sub_cls = CLS_HIGH;
      end else if (prio_ff >= $signed({1'b0, low_th_ff})) begin
         sub_cls = CLS_LOW;
      end else begin
         sub_cls = CLS_STD;
      end
      sub_full = (cnt[sub_cls] == CW'(CLASS_DEPTH));
   end

   // Unpack the entry under the scan index of the selected class
   assign sel_e     = rd_e[sel_cls_ff];
   assign sel_prio  = $signed(sel_e[EW-1 -: PRIO_BITS]);
   assign sel_recv  = sel_e[TB +: RB];
   assign sel_tag   = sel_e[TB-1:0];
   assign scan_end  = (idx_ff >= cnt[sel_cls_ff]);
   assign sweep_hit = !scan_end && (sel_recv == recv_ff);
   assign new_entry = {prio_ff, recv_ff, tag_ff};

   // Choose class and lane: high first, spill to lower lanes
   always_comb begin
      free0     = active_ff[0] < lim_ff[0];
      free1     = active_ff[1] < lim_ff[1];
      free2     = active_ff[2] < lim_ff[2];
      pick_go   = 1'b0;
      pick_cls  = CLS_LOW;
      pick_lane = CLS_LOW;
      if (cnt[CLS_HIGH] != '0) begin
         pick_cls  = CLS_HIGH;
         pick_go   = free0 || free1 || free2;
         pick_lane = free0 ? CLS_HIGH : (free1 ? CLS_STD : CLS_LOW);
      end else if (cnt[CLS_STD] != '0) begin
         pick_cls  = CLS_STD;
         pick_go   = free1 || free2;
         pick_lane = free1 ? CLS_STD : CLS_LOW;
      end else if (cnt[CLS_LOW] != '0) begin
         pick_go   = free2;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (req_fire) state_in = S_OP;
         S_OP:    state_in = (op_ff == OP_CANCEL_RECV) ? S_SWEEP : S_PICK;
         S_SWEEP: if (scan_end && sel_cls_ff == CLS_LOW) state_in = S_PICK;
         S_PICK:  state_in = pick_go ? S_SCAN : S_DONE;
         S_SCAN:  if (scan_end) state_in = S_TAKE;
         S_TAKE:  state_in = S_DONE;
         S_DONE:  if (push_ok) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Store commands
   always_comb begin
      for (int c = 0; c < NUM_CLS; c++) begin
         cmd[c] = '0;
      end
      pos = (state_ff == S_TAKE) ? best_idx_ff : idx_ff[IW-1:0];
      unique case (state_ff)
         S_OP: begin
            if (op_ff == OP_SUBMIT && !sub_full) begin
               cmd[sub_cls].append = 1'b1;
            end
            if (op_ff == OP_CANCEL_ALL) begin
               for (int c = 0; c < NUM_CLS; c++) begin
                  cmd[c].clear = 1'b1;
               end
            end
         end
         S_SWEEP: if (sweep_hit) cmd[sel_cls_ff].remove = 1'b1;
         S_TAKE:  cmd[sel_cls_ff].remove = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         lim_ff[0]    <= 8'd1;
         lim_ff[1]    <= 8'd1;
         lim_ff[2]    <= 8'd1;
         high_th_ff   <= -16'sd1;
         low_th_ff    <= 15'd1;
         active_ff[0] <= '0;
         active_ff[1] <= '0;
         active_ff[2] <= '0;
         sched_ff     <= '0;
         proc_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;

         // Take register writes
         if (csr_wen) begin
            case (csr_addr)
               REG_HIGH_LIMIT: lim_ff[0]  <= csr_wdata[7:0];
               REG_STD_LIMIT:  lim_ff[1]  <= csr_wdata[7:0];
               REG_LOW_LIMIT:  lim_ff[2]  <= csr_wdata[7:0];
               REG_HIGH_TH:    high_th_ff <= $signed(csr_wdata);
               REG_LOW_TH:     low_th_ff  <= csr_wdata[14:0];
               default: ;
            endcase
         end

         // Raise the response beat when there is room, drop it once taken
         if (state_ff == S_DONE && push_ok) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_OP: begin
               case (op_ff)
                  OP_SUBMIT: begin
                     if (sub_full) proc_ff <= proc_ff + 32'd1;
                     else          sched_ff <= sched_ff + 32'd1;
                  end
                  OP_COMPLETE: begin
                     if (lane_ff != CLS_LOW + 2'd1 && active_ff[lane_ff] != '0) begin
                        active_ff[lane_ff] <= active_ff[lane_ff] - 8'd1;
                        proc_ff            <= proc_ff + 32'd1;
                     end
                  end
                  OP_CANCEL_ALL: begin
                     proc_ff <= proc_ff + 32'(cnt[0]) + 32'(cnt[1]) + 32'(cnt[2]);
                  end
                  default: ;
               endcase
            end
            S_SWEEP: if (sweep_hit) proc_ff <= proc_ff + 32'd1;
            S_TAKE:  active_ff[iss_lane_ff] <= active_ff[iss_lane_ff] + 8'd1;
            default: ;
         endcase
      end
   end

   // Payload and datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_ff   <= req_tuser;
               prio_ff <= $signed(req_tdata[PRIO_BITS-1:0]);
               recv_ff <= req_tdata[PRIO_BITS +: RB];
               tag_ff  <= req_tdata[PRIO_BITS+RB +: TB];
               lane_ff <= req_tdata[PRIO_BITS+RB+TB +: 2];
            end
         end
         S_OP: begin
            iss_valid_ff <= 1'b0;
            best_tag_ff  <= '0;
            best_recv_ff <= '0;
            iss_lane_ff  <= '0;
            sel_cls_ff   <= CLS_HIGH;
            idx_ff       <= '0;
            status_ff    <= ST_OK;
            if (op_ff == OP_SUBMIT && sub_full) begin
               status_ff <= ST_FULL;
            end
            if (op_ff == OP_COMPLETE &&
                (lane_ff == CLS_LOW + 2'd1 || active_ff[lane_ff] == '0)) begin
               status_ff <= ST_IDLE_LANE;
            end
         end
         S_SWEEP: begin
            // Advance past a kept entry; after a removal the row moved under us
            if (scan_end) begin
               if (sel_cls_ff != CLS_LOW) begin
                  sel_cls_ff <= sel_cls_ff + 2'd1;
               end
               idx_ff <= '0;
            end else if (!sweep_hit) begin
               idx_ff <= idx_ff + 1'b1;
            end
         end
         S_PICK: begin
            sel_cls_ff <= pick_cls;
            if (pick_go) begin
               iss_lane_ff <= pick_lane;
            end
            idx_ff <= '0;
         end
         S_SCAN: begin
            // Keep the first strictly smaller priority: oldest wins a tie
            if (!scan_end) begin
               if (idx_ff == '0 || sel_prio < best_prio_ff) begin
                  best_prio_ff <= sel_prio;
                  best_idx_ff  <= idx_ff[IW-1:0];
                  best_tag_ff  <= sel_tag;
                  best_recv_ff <= sel_recv;
               end
               idx_ff <= idx_ff + 1'b1;
            end
         end
         S_TAKE: iss_valid_ff <= 1'b1;
         S_DONE: begin
            if (push_ok) begin
               rsp_data_ff <= RSP_W'({proc_ff, sched_ff, status_ff, iss_lane_ff,
                                      best_recv_ff, best_tag_ff, iss_valid_ff});
            end
         end
         default: ;
      endcase
   end
endmodule
`default_nettype wire

>>> design/tcls_cell.sv
// One slot of a class store: loads a new entry or takes its right neighbor's entry.
`default_nettype none
module tcls_cell #(
   parameter int ENTRY_BITS = 40
) (
   input  wire logic                  clock,
   input  wire logic                  load,
   input  wire logic                  shift,
   input  wire logic [ENTRY_BITS-1:0] load_data,
   input  wire logic [ENTRY_BITS-1:0] next_data,
   output logic      [ENTRY_BITS-1:0] data_q
);
   logic [ENTRY_BITS-1:0] data_ff, data_in;

   // Load a fresh entry, or close the gap by taking the neighbor's entry
   always_comb begin
      data_in = data_ff;
      if (load) begin
         data_in = load_data;
      end else if (shift) begin
         data_in = next_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_q = data_ff;
endmodule
`default_nettype wire

>>> design/tcls_store.sv
// Class store: a row of cells kept in arrival order, with append, remove-at and clear.
`default_nettype none
module tcls_store #(
   parameter int DEPTH      = 16,
   parameter int ENTRY_BITS = 40,
   parameter int IDX_BITS   = 4,
   parameter int CNT_BITS   = 5
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire tcls_pkg::store_cmd_type cmd,
   input  wire logic [IDX_BITS-1:0]     pos,
   input  wire logic [ENTRY_BITS-1:0]   new_entry,
   input  wire logic [IDX_BITS-1:0]     rd_idx,
   output logic      [ENTRY_BITS-1:0]   rd_entry,
   output logic      [CNT_BITS-1:0]     count
);
   import tcls_pkg::*;

   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic [ENTRY_BITS-1:0] cell_q [DEPTH];

   // Build the row; the last cell takes zeros when shifting
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [ENTRY_BITS-1:0] nxt;
      if (i == DEPTH - 1) begin : g_end
         assign nxt = '0;
      end else begin : g_mid
         assign nxt = cell_q[i+1];
      end
      tcls_cell #(.ENTRY_BITS(ENTRY_BITS)) u_cell (
         .clock     (clock),
         .load      (cmd.append && (count_ff == CNT_BITS'(i))),
         .shift     (cmd.remove && (IDX_BITS'(i) >= pos)),
         .load_data (new_entry),
         .next_data (nxt),
         .data_q    (cell_q[i])
      );
   end

   // Track the fill level
   always_comb begin
      count_in = count_ff;
      if (cmd.clear) begin
         count_in = '0;
      end else if (cmd.append) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.remove) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign count    = count_ff;
   assign rd_entry = cell_q[rd_idx];
endmodule
`default_nettype wire

>>> test/tb.sv
// Self-checking testbench for the three-class lane credit scheduler top level.
`timescale 1ns / 1ps
module tb;
   import tcls_pkg::*;

   localparam int DEPTH = 16;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      logic [1:0]         op;
      logic signed [15:0] prio;
      logic [7:0]         recv;
      logic [15:0]        tag;
      logic [1:0]         lane;
   } req_t;

   typedef struct {
      logic        valid;
      logic [15:0] tag;
      logic [7:0]  recv;
      logic [1:0]  lane;
      logic [1:0]  status;
      logic [31:0] sched;
      logic [31:0] proc_cnt;
   } rsp_t;

   typedef struct {
      logic signed [15:0] prio;
      logic [7:0]         recv;
      logic [15:0]        tag;
   } cmd_t;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [1:0]  req_tuser = '0;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [95:0] rsp_tdata;
   logic        csr_wen = 0;
   logic [2:0]  csr_addr = '0;
   logic [15:0] csr_wdata = '0;

   req_t pending_reqs[$];
   rsp_t expected_rsps[$];
   req_t cur_req;
   bit   beat_taken = 0;
   bit   calm = 0;
   int   errors = 0;
   int   cycles = 0;

   // scheduler shadow state
   cmd_t        class_q[3][$];
   int          active_cnt[3];
   logic [7:0]  lane_limit[3];
   logic signed [15:0] high_th;
   logic [14:0] low_th;
   logic [31:0] sched_total, proc_total;

   three_class_lane_credit_scheduler_top uut (.*);

   always #2 clock = ~clock;

   task automatic report(input string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
   endtask

   // apply one accepted beat to the shadow state and queue its result
   task automatic schedule_step(input req_t r);
      rsp_t e;
      int   cls, best;
      e = '{default: '0};
      if (r.op == OP_SUBMIT) begin
         if (r.prio <= high_th) cls = CLS_HIGH;
         else if (int'(r.prio) >= int'({1'b0, low_th})) cls = CLS_LOW;
         else cls = CLS_STD;
         if (class_q[cls].size() >= DEPTH) begin
            e.status = ST_FULL;
            proc_total++;
         end else begin
            class_q[cls].push_back('{r.prio, r.recv, r.tag});
            sched_total++;
         end
      end else if (r.op == OP_COMPLETE) begin
         if (r.lane > 2 || active_cnt[r.lane] == 0) e.status = ST_IDLE_LANE;
         else begin
            active_cnt[r.lane]--;
            proc_total++;
         end
      end else begin
         for (int c = 0; c < 3; c++)
            for (int i = class_q[c].size() - 1; i >= 0; i--)
               if (r.op == OP_CANCEL_ALL || class_q[c][i].recv == r.recv) begin
                  class_q[c].delete(i);
                  proc_total++;
               end
      end
      // issue at most one command: first waiting class decides
      for (int c = 0; c < 3; c++) begin
         if (class_q[c].size() > 0) begin
            for (int l = c; l < 3; l++) begin
               if (active_cnt[l] < lane_limit[l]) begin
                  best = 0;
                  foreach (class_q[c][i])
                     if (class_q[c][i].prio < class_q[c][best].prio) best = i;
                  e.valid = 1;
                  e.tag   = class_q[c][best].tag;
                  e.recv  = class_q[c][best].recv;
                  e.lane  = l[1:0];
                  active_cnt[l]++;
                  class_q[c].delete(best);
                  break;
               end
            end
            break;
         end
      end
      e.sched = sched_total;
      e.proc_cnt = proc_total;
      expected_rsps.push_back(e);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
      @(negedge clock);
      csr_wen <= 1;
      csr_addr <= idx;
      csr_wdata <= val;
      case (idx)
         REG_HIGH_LIMIT: lane_limit[CLS_HIGH] = val[7:0];
         REG_STD_LIMIT:  lane_limit[CLS_STD] = val[7:0];
         REG_LOW_LIMIT:  lane_limit[CLS_LOW] = val[7:0];
         REG_HIGH_TH:    high_th = val;
         default:        low_th = val[14:0];
      endcase
      @(negedge clock);
      csr_wen <= 0;
   endtask

   task automatic set_config(input int hl, sl, ll, input int hth, lth);
      write_reg(REG_HIGH_LIMIT, 16'(hl));
      write_reg(REG_STD_LIMIT, 16'(sl));
      write_reg(REG_LOW_LIMIT, 16'(ll));
      write_reg(REG_HIGH_TH, 16'(hth));
      write_reg(REG_LOW_TH, 16'(lth));
   endtask

   function automatic req_t make_req(input logic [1:0] op, input int prio, input int recv,
                                     input int tag, input int lane);
      req_t r;
      r.op = op;
      r.prio = 16'(prio);
      r.recv = 8'(recv);
      r.tag = 16'(tag);
      r.lane = 2'(lane);
      return r;
   endfunction

   function automatic req_t random_req();
      int   pick;
      req_t r;
      pick = $urandom_range(0, 99);
      r.prio = 16'($urandom);
      if ($urandom_range(0, 2) != 0) r.prio = 16'($urandom_range(0, 400)) - 16'sd200;
      r.recv = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 7)) : 8'($urandom);
      r.tag = 16'($urandom);
      r.lane = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
      if (pick < 55) r.op = OP_SUBMIT;
      else if (pick < 88) r.op = OP_COMPLETE;
      else if (pick < 97) r.op = OP_CANCEL_RECV;
      else r.op = OP_CANCEL_ALL;
      return r;
   endfunction

   task automatic wait_drained();
      while (pending_reqs.size() > 0 || expected_rsps.size() > 0 || req_tvalid)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // accept request beats and predict
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         schedule_step(cur_req);
         beat_taken <= 1;
      end
   end

   // drive request beats at the falling edge
   always @(negedge clock) begin
      beat_taken <= 0;
      rsp_tready <= calm || ($urandom_range(0, 99) >= 35);
      if (!reset && (!req_tvalid || beat_taken)) begin
         if (pending_reqs.size() > 0 && (calm || $urandom_range(0, 99) >= 35)) begin
            cur_req = pending_reqs.pop_front();
            req_tvalid <= 1;
            req_tuser <= cur_req.op;
            req_tdata <= {6'b0, cur_req.lane, cur_req.tag, cur_req.recv, cur_req.prio};
         end else begin
            req_tvalid <= 0;
         end
      end
   end

   // check response beats
   always @(posedge clock) begin
      rsp_t e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_rsps.size() == 0) report("response beat with nothing expected");
         else begin
            e = expected_rsps.pop_front();
            if (rsp_tdata[0] !== e.valid)
               report($sformatf("issue_valid %0b exp %0b", rsp_tdata[0], e.valid));
            if (rsp_tdata[16:1] !== e.tag)
               report($sformatf("issue_tag %0h exp %0h", rsp_tdata[16:1], e.tag));
            if (rsp_tdata[24:17] !== e.recv)
               report($sformatf("issue_receiver %0h exp %0h", rsp_tdata[24:17], e.recv));
            if (rsp_tdata[26:25] !== e.lane)
               report($sformatf("issue_lane %0d exp %0d", rsp_tdata[26:25], e.lane));
            if (rsp_tdata[28:27] !== e.status)
               report($sformatf("status %0d exp %0d", rsp_tdata[28:27], e.status));
            if (rsp_tdata[60:29] !== e.sched)
               report($sformatf("scheduled_count %0d exp %0d", rsp_tdata[60:29], e.sched));
            if (rsp_tdata[92:61] !== e.proc_cnt)
               report($sformatf("processed_count %0d exp %0d", rsp_tdata[92:61], e.proc_cnt));
         end
      end
   end

   // hold a cycle limit on the whole run
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      for (int l = 0; l < 3; l++) begin
         active_cnt[l] = 0;
         lane_limit[l] = 8'd1;
      end
      high_th = -16'sd1;
      low_th = 15'd1;
      sched_total = 0;
      proc_total = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: field extremes, idle and unknown lanes, cancels, class overflow
      pending_reqs.push_back(make_req(OP_SUBMIT, -32768, 255, 16'hffff, 0));
      pending_reqs.push_back(make_req(OP_SUBMIT, 32767, 0, 0, 3));
      pending_reqs.push_back(make_req(OP_SUBMIT, 0, 8'haa, 16'h5555, 0));
      pending_reqs.push_back(make_req(OP_COMPLETE, 0, 0, 0, 3));
      pending_reqs.push_back(make_req(OP_COMPLETE, 0, 0, 0, 1));
      for (int i = 0; i < 17; i++)
         pending_reqs.push_back(make_req(OP_SUBMIT, 100 - i % 3, i % 4, i, 2));
      pending_reqs.push_back(make_req(OP_CANCEL_RECV, 0, 1, 0, 0));
      pending_reqs.push_back(make_req(OP_COMPLETE, 0, 0, 0, 2));
      pending_reqs.push_back(make_req(OP_CANCEL_ALL, 0, 0, 0, 0));
      wait_drained();

      // random phases over several register settings
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: set_config(2, 2, 2, -100, 100);
            1: set_config(0, 0, 1, -32768, 32767);
            2: set_config(255, 255, 255, -1, 1);
            3: set_config(1, 0, 3, -200, 1);
            default: set_config($urandom_range(0, 4), $urandom_range(0, 4),
                                 $urandom_range(1, 4), -$urandom_range(1, 300),
                                 $urandom_range(1, 300));
         endcase
         calm = (ph == 2);
         for (int i = 0; i < 90; i++) pending_reqs.push_back(random_req());
         wait_drained();
      end
      calm = 0;

      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
